[design/bem_pkg.sv]
// ----------------------------------------------------------------------------
// bem_pkg
// Shared types and constants for the shift-or exact string matcher.
// ----------------------------------------------------------------------------
package bem_pkg;

    // Width of the shift-or state vector; one spare bit above the longest pattern
    localparam int VEC_BITS     = 64;
    localparam int OUT_POS_BITS = 32;
    localparam int LEN_BITS     = 6;
    localparam int IDX_BITS     = 6;
    localparam int BYTE_BITS    = 8;

    localparam logic [VEC_BITS-1:0] VEC_RESET = ~VEC_BITS'(1);

    // Input operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TEXT  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_END   = 2'd3;

    // Result kinds
    localparam logic RES_MATCH    = 1'b0;
    localparam logic RES_NO_MATCH = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_TEXT,
        CMD_START,
        CMD_END
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind               kind;
        logic [IDX_BITS-1:0]     index;
        logic [BYTE_BITS-1:0]    data;
    } t_cmd;

    typedef struct packed {
        logic                    kind;
        logic [OUT_POS_BITS-1:0] position;
    } t_result;

endpackage

[design/bem_front.sv]
// ----------------------------------------------------------------------------
// bem_front
// Accepts input transactions and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module bem_front
    import bem_pkg::*;
#(
    parameter int MAX_PATTERN = 63
) (
    input  logic                 i_push,
    input  logic [1:0]           i_op,
    input  logic [IDX_BITS-1:0]  i_pattern_index,
    input  logic [BYTE_BITS-1:0] i_data_byte,
    input  logic                 i_q_full,
    output logic                 o_full,
    output logic                 o_q_push,
    output t_cmd                 o_cmd
);

    logic accept;
    logic drop;

    assign accept = i_push & ~i_q_full;
    assign o_full = i_q_full;

    // Loads beyond the pattern store are swallowed here
    assign drop = (i_op == OP_LOAD) && (i_pattern_index >= IDX_BITS'(MAX_PATTERN));

    always_comb begin
        o_cmd.index = i_pattern_index;
        o_cmd.data  = i_data_byte;
        case (i_op)
            OP_LOAD:  o_cmd.kind = CMD_LOAD;
            OP_TEXT:  o_cmd.kind = CMD_TEXT;
            OP_START: o_cmd.kind = CMD_START;
            OP_END:   o_cmd.kind = CMD_END;
            default:  o_cmd.kind = CMD_TEXT;
        endcase
    end

    assign o_q_push = accept & ~drop;

endmodule

[design/bem_fifo.sv]
// ----------------------------------------------------------------------------
// bem_fifo
// Small synchronous queue with full/empty flags and head shown while not empty.
// ----------------------------------------------------------------------------
module bem_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/bem_back.sv]
// ----------------------------------------------------------------------------
// bem_back
// Executes commands: pattern store writes, shift-or update, result generation.
// ----------------------------------------------------------------------------
module bem_back
    import bem_pkg::*;
#(
    parameter int MAX_PATTERN   = 63,
    parameter int POSITION_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [LEN_BITS-1:0] i_cfg_pattern_length,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_take,
    input  logic                i_res_full,
    output logic                o_res_push,
    output t_result             o_res
);

    localparam int SW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int WB = (POSITION_BITS > OUT_POS_BITS) ? POSITION_BITS : OUT_POS_BITS;

    logic [BYTE_BITS-1:0]     r_store [MAX_PATTERN];
    logic [LEN_BITS-1:0]      r_len;
    logic [VEC_BITS-1:0]      r_vec;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_found;

    logic [LEN_BITS-1:0]      used_len;
    logic [VEC_BITS-1:0]      mask;
    logic [VEC_BITS-1:0]      or_vec;
    logic                     hit;
    logic [POSITION_BITS-1:0] start_pos;
    logic [WB-1:0]            start_ext;

    assign o_cmd_take = i_cmd_valid & ~i_res_full;

    // Length clamped into 1..MAX_PATTERN
    always_comb begin
        if (r_len == '0) begin
            used_len = LEN_BITS'(1);
        end else if (r_len > LEN_BITS'(MAX_PATTERN)) begin
            used_len = LEN_BITS'(MAX_PATTERN);
        end else begin
            used_len = r_len;
        end
    end

    always_comb begin
        mask = '1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if ((LEN_BITS'(i) < used_len) && (r_store[i] == i_cmd.data)) begin
                mask[i] = 1'b0;
            end
        end
    end

    assign or_vec    = r_vec | mask;
    // Bit used_len of the shifted vector is bit used_len-1 before the shift
    assign hit       = ~or_vec[used_len - LEN_BITS'(1)];
    assign start_pos = r_pos + POSITION_BITS'(1) - POSITION_BITS'(used_len);
    assign start_ext = WB'(start_pos);

    always_comb begin
        o_res_push = 1'b0;
        case (i_cmd.kind)
            CMD_TEXT: o_res_push = o_cmd_take & hit;
            CMD_END:  o_res_push = o_cmd_take & ~r_found;
            default:  o_res_push = 1'b0;
        endcase
        if (i_cmd.kind == CMD_END) begin
            o_res.kind     = RES_NO_MATCH;
            o_res.position = '0;
        end else begin
            o_res.kind     = RES_MATCH;
            o_res.position = start_ext[OUT_POS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LEN_BITS'(1);
            r_vec   <= VEC_RESET;
            r_pos   <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_pattern_length;
            end
            if (o_cmd_take) begin
                case (i_cmd.kind)
                    CMD_TEXT: begin
                        r_vec <= {or_vec[VEC_BITS-2:0], 1'b0};
                        if (hit) begin
                            r_found <= 1'b1;
                        end
                        if (r_pos != '1) begin
                            r_pos <= r_pos + POSITION_BITS'(1);
                        end
                    end
                    CMD_START: begin
                        r_vec   <= VEC_RESET;
                        r_pos   <= '0;
                        r_found <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take && (i_cmd.kind == CMD_LOAD)) begin
            r_store[i_cmd.index[SW-1:0]] <= i_cmd.data;
        end
    end

endmodule

[design/bitap_exact_match.sv]
// Result path: an accepted transaction is registered in the command queue, and its
//   result is registered in the result queue before it shows on the result ports.
// Throughput: one transaction per cycle, set by the shift-or update
//   in the back end (parallel compare, OR, shift) while results are being drained.
// Reset: synchronous, active low; clears both queues, the state vector, position,
//   found flag and sets the pattern length to one. The pattern store is not cleared.
// ----------------------------------------------------------------------------
// bitap_exact_match
// Shift-or exact string matcher with queue-style input and result ports.
// ----------------------------------------------------------------------------
module bitap_exact_match
    import bem_pkg::*;
#(
    parameter int MAX_PATTERN   = 63,
    parameter int POSITION_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration: pattern length
    input  logic                    i_cfg_wr_en,
    input  logic [LEN_BITS-1:0]     i_cfg_pattern_length,
    // input queue side
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_op,
    input  logic [IDX_BITS-1:0]     i_pattern_index,
    input  logic [BYTE_BITS-1:0]    i_data_byte,
    // result queue side
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_kind,
    output logic [OUT_POS_BITS-1:0] o_match_position
);

    // Command queue depth between front and back end
    localparam int CMD_DEPTH = 4;
    // Result queue depth: two entries keep a full-rate stream with pop held high
    localparam int RES_DEPTH = 2;

    logic    cmd_q_full, cmd_q_empty, cmd_q_push, cmd_take;
    t_cmd    front_cmd, back_cmd;
    logic    res_q_full, res_push;
    t_result back_res, head_res;

    // Front end: classifies each transaction, drops loads outside the store
    bem_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_push          (push),
        .i_op            (i_op),
        .i_pattern_index (i_pattern_index),
        .i_data_byte     (i_data_byte),
        .i_q_full        (cmd_q_full),
        .o_full          (full),
        .o_q_push        (cmd_q_push),
        .o_cmd           (front_cmd)
    );

    // Decouples intake from execution
    bem_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_q_push),
        .i_data  (front_cmd),
        .i_pop   (cmd_take),
        .o_data  (back_cmd),
        .o_full  (cmd_q_full),
        .o_empty (cmd_q_empty)
    );

    // Back end: in-order execution of loads, text bytes, start and end markers
    bem_back #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_pattern_length (i_cfg_pattern_length),
        .i_cmd_valid          (~cmd_q_empty),
        .i_cmd                (back_cmd),
        .o_cmd_take           (cmd_take),
        .i_res_full           (res_q_full),
        .o_res_push           (res_push),
        .o_res                (back_res)
    );

    // Result queue: results wait here for the consumer
    bem_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .i_pop   (pop),
        .o_data  (head_res),
        .o_full  (res_q_full),
        .o_empty (empty)
    );

    assign o_kind           = head_res.kind;
    assign o_match_position = head_res.position;

endmodule

[design/bem_checker.sv]
// ----------------------------------------------------------------------------
// bem_checker
// Port-level checks for the matcher, bound onto the top level.
// ----------------------------------------------------------------------------
module bem_checker
    import bem_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    push,
    input logic                    full,
    input logic                    empty,
    input logic                    pop,
    input logic                    o_kind,
    input logic [OUT_POS_BITS-1:0] o_match_position
);

    // Queues come out of reset empty with room for input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    // A no-match result always reports position zero
    a_nomatch_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == RES_NO_MATCH)) |-> (o_match_position == '0))
        else $error("no-match result with nonzero position");

    // Input side only fills up through pushes
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a push");

    // A waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_match_position)))
        else $error("waiting result changed");

endmodule

bind bitap_exact_match bem_checker u_bem_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .push             (push),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .o_kind           (o_kind),
    .o_match_position (o_match_position)
);
